FILE: rtl/core/utf8_stream_decoder_macros.svh
// Assertion macros for the UTF-8 stream decoder.
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

`ifndef SYNTH
`define UTF8SD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("utf8sd assertion failed");
`define UTF8SD_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("utf8sd assertion failed");
`else
`define UTF8SD_ASSERT(lbl, prop)
`define UTF8SD_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

FILE: rtl/core/utf8sd_pkg.sv
package utf8sd_pkg;

  localparam int OFFSET_BITS_DEF = 32;

  localparam logic [7:0] ASCII_MIN   = 8'h01;
  localparam logic [7:0] ASCII_MAX   = 8'h7F;
  localparam logic [7:0] LEAD2_MIN   = 8'hC2;
  localparam logic [7:0] LEAD2_MAX   = 8'hDF;
  localparam logic [7:0] LEAD3_MAX   = 8'hEF;
  localparam logic [7:0] LEAD4_MAX   = 8'hF4;
  localparam logic [7:0] LEAD_E0     = 8'hE0;
  localparam logic [7:0] LEAD_ED     = 8'hED;
  localparam logic [7:0] LEAD_F0     = 8'hF0;
  localparam logic [7:0] LEAD_F4     = 8'hF4;
  localparam logic [7:0] LIMIT_A0    = 8'hA0;
  localparam logic [7:0] LIMIT_90    = 8'h90;
  localparam logic [7:0] CONT_MASK   = 8'hC0;
  localparam logic [7:0] CONT_TAG    = 8'h80;
  localparam logic [7:0] PAYLOAD_6   = 8'h3F;

  typedef enum logic [1:0] {
    ST_VALID     = 2'd0,
    ST_INVALID   = 2'd1,
    ST_TRUNCATED = 2'd2
  } status_t;

  typedef struct packed {
    logic [20:0] codepoint;
    logic [2:0]  char_width;
    status_t     status;
    logic [31:0] char_start_offset;
    logic [31:0] char_number;
    logic        final_result;
  } result_t;

endpackage

FILE: rtl/core/utf8sd_core.sv
module utf8sd_core #(
  parameter int OFFSET_BITS = utf8sd_pkg::OFFSET_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  input  logic                end_of_text,
  output logic                res_valid,
  output utf8sd_pkg::result_t res
);
  import utf8sd_pkg::*;

  logic [7:0]             lead_value_r, lead_value_nxt;
  logic [20:0]            partial_point_r, partial_point_nxt;
  logic [2:0]             bytes_needed_r, bytes_needed_nxt;
  logic [2:0]             bytes_seen_r, bytes_seen_nxt;
  logic [OFFSET_BITS-1:0] byte_position_r, byte_position_nxt;
  logic [OFFSET_BITS-1:0] sequence_start_r, sequence_start_nxt;
  logic [31:0]            chars_done_r, chars_done_nxt;
  logic                   error_latched_r, error_latched_nxt;

  logic                   hit;
  logic                   cont_ok;
  logic [2:0]             seen_inc;
  logic [20:0]            shifted_point;

  assign seen_inc      = bytes_seen_r + 3'd1;
  assign shifted_point = {partial_point_r[14:0], data_byte[5:0] & PAYLOAD_6[5:0]};

  always_comb begin
    cont_ok = (data_byte & CONT_MASK) == CONT_TAG;
    if (bytes_seen_r == 3'd1) begin
      if (lead_value_r == LEAD_E0 && data_byte < LIMIT_A0) cont_ok = 1'b0;
      if (lead_value_r == LEAD_ED && data_byte >= LIMIT_A0) cont_ok = 1'b0;
      if (lead_value_r == LEAD_F0 && data_byte < LIMIT_90) cont_ok = 1'b0;
      if (lead_value_r == LEAD_F4 && data_byte >= LIMIT_90) cont_ok = 1'b0;
    end
  end

  always_comb begin
    lead_value_nxt     = lead_value_r;
    partial_point_nxt  = partial_point_r;
    bytes_needed_nxt   = bytes_needed_r;
    bytes_seen_nxt     = bytes_seen_r;
    byte_position_nxt  = byte_position_r + OFFSET_BITS'(1);
    sequence_start_nxt = sequence_start_r;
    chars_done_nxt     = chars_done_r;
    error_latched_nxt  = error_latched_r;
    hit                = 1'b0;
    res.codepoint         = '0;
    res.char_width        = '0;
    res.status            = ST_INVALID;
    res.char_start_offset = 32'(byte_position_r);
    res.char_number       = chars_done_r;
    res.final_result      = end_of_text;

    if (error_latched_r) begin
      hit = 1'b0;
    end else if (bytes_needed_r == 3'd0) begin
      if (data_byte >= ASCII_MIN && data_byte <= ASCII_MAX) begin
        hit            = 1'b1;
        res.codepoint  = {13'd0, data_byte};
        res.char_width = 3'd1;
        res.status     = ST_VALID;
        chars_done_nxt = chars_done_r + 32'd1;
      end else if (data_byte >= LEAD2_MIN && data_byte <= LEAD4_MAX) begin
        lead_value_nxt     = data_byte;
        bytes_seen_nxt     = 3'd1;
        sequence_start_nxt = byte_position_r;
        if (data_byte <= LEAD2_MAX) begin
          bytes_needed_nxt  = 3'd2;
          partial_point_nxt = {16'd0, data_byte[4:0]};
        end else if (data_byte <= LEAD3_MAX) begin
          bytes_needed_nxt  = 3'd3;
          partial_point_nxt = {17'd0, data_byte[3:0]};
        end else begin
          bytes_needed_nxt  = 3'd4;
          partial_point_nxt = {18'd0, data_byte[2:0]};
        end
        if (end_of_text) begin
          hit               = 1'b1;
          res.status        = ST_TRUNCATED;
          error_latched_nxt = 1'b1;
        end
      end else begin
        hit               = 1'b1;
        res.status        = ST_INVALID;
        error_latched_nxt = 1'b1;
      end
    end else begin
      res.char_start_offset = 32'(sequence_start_r);
      if (!cont_ok) begin
        hit               = 1'b1;
        res.status        = ST_INVALID;
        error_latched_nxt = 1'b1;
        bytes_needed_nxt  = '0;
        bytes_seen_nxt    = '0;
        partial_point_nxt = '0;
        lead_value_nxt    = '0;
      end else begin
        partial_point_nxt = shifted_point;
        bytes_seen_nxt    = seen_inc;
        if (seen_inc >= bytes_needed_r) begin
          hit               = 1'b1;
          res.codepoint     = shifted_point;
          res.char_width    = bytes_needed_r;
          res.status        = ST_VALID;
          chars_done_nxt    = chars_done_r + 32'd1;
          bytes_needed_nxt  = '0;
          bytes_seen_nxt    = '0;
          partial_point_nxt = '0;
          lead_value_nxt    = '0;
        end else if (end_of_text) begin
          hit               = 1'b1;
          res.status        = ST_TRUNCATED;
          error_latched_nxt = 1'b1;
        end
      end
    end

    if (end_of_text) begin
      lead_value_nxt     = '0;
      partial_point_nxt  = '0;
      bytes_needed_nxt   = '0;
      bytes_seen_nxt     = '0;
      byte_position_nxt  = '0;
      sequence_start_nxt = '0;
      chars_done_nxt     = '0;
      error_latched_nxt  = 1'b0;
    end
  end

  assign res_valid = accept & hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_value_r     <= '0;
      partial_point_r  <= '0;
      bytes_needed_r   <= '0;
      bytes_seen_r     <= '0;
      byte_position_r  <= '0;
      sequence_start_r <= '0;
      chars_done_r     <= '0;
      error_latched_r  <= 1'b0;
    end else if (accept) begin
      lead_value_r     <= lead_value_nxt;
      partial_point_r  <= partial_point_nxt;
      bytes_needed_r   <= bytes_needed_nxt;
      bytes_seen_r     <= bytes_seen_nxt;
      byte_position_r  <= byte_position_nxt;
      sequence_start_r <= sequence_start_nxt;
      chars_done_r     <= chars_done_nxt;
      error_latched_r  <= error_latched_nxt;
    end
  end

`include "utf8_stream_decoder_macros.svh"

  `UTF8SD_ASSERT(a_latch_closes_seq, !error_latched_r || bytes_needed_r == 3'd0)
  `UTF8SD_ASSERT(a_seen_in_range, bytes_needed_r == 3'd0 ||
                 (bytes_seen_r != 3'd0 && bytes_seen_r < bytes_needed_r))
  `UTF8SD_ASSERT_NEXT(a_final_clears, accept && end_of_text,
                      byte_position_r == '0 && !error_latched_r && chars_done_r == 32'd0)

endmodule

FILE: rtl/core/utf8sd_out_buf.sv
module utf8sd_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_valid,
  input  utf8sd_pkg::result_t res,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output utf8sd_pkg::result_t out_res
);
  import utf8sd_pkg::*;

  logic    out_valid_r;
  logic    skid_valid_r;
  result_t out_q_r;
  result_t skid_q_r;
  logic    pop;

  assign pop       = out_valid_r & out_ready;
  assign in_ready  = ~skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_q_r <= skid_q_r;
      end else if (res_valid) begin
        out_q_r <= res;
      end
    end else if (res_valid) begin
      skid_q_r <= res;
    end
  end

`include "utf8_stream_decoder_macros.svh"

  `UTF8SD_ASSERT(a_skid_behind_out, !skid_valid_r || out_valid_r)
  `UTF8SD_ASSERT(a_no_push_when_full, !(res_valid && skid_valid_r))
  `UTF8SD_ASSERT_NEXT(a_stall_fills_skid, res_valid && out_valid_r && !out_ready, skid_valid_r && out_valid_r)

endmodule

FILE: rtl/core/utf8_stream_decoder.sv
// Results are registered in the output stage before they show on the out_ ports.
// Throughput: one byte per cycle; a two-entry output stage keeps in_ready high
// unless two results are held while the sink stalls.
// Reset: synchronous, active low rst_n clears decode state, offsets, counters
// and the output stage. The final byte of a buffer also returns state to reset.
module utf8_stream_decoder #(
  parameter int OFFSET_BITS = utf8sd_pkg::OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] out_codepoint,
  output logic [2:0]  out_char_width,
  output logic [1:0]  out_status,
  output logic [31:0] out_char_start_offset,
  output logic [31:0] out_char_number,
  output logic        out_final_result
);
  import utf8sd_pkg::*;

  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign accept = in_valid & in_ready;

  utf8sd_core #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .data_byte  (in_data_byte),
    .end_of_text(in_end_of_text),
    .res_valid  (res_valid),
    .res        (res)
  );

  utf8sd_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_valid(res_valid),
    .res      (res),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res  (out_res)
  );

  assign out_codepoint         = out_res.codepoint;
  assign out_char_width        = out_res.char_width;
  assign out_status            = out_res.status;
  assign out_char_start_offset = out_res.char_start_offset;
  assign out_char_number       = out_res.char_number;
  assign out_final_result      = out_res.final_result;

endmodule
